### rtl/core/heater_bus_packet_check_decode_assert.svh
// assertion macros for the packet checker
`ifndef HEATER_BUS_PACKET_CHECK_DECODE_ASSERT_SVH
`define HEATER_BUS_PACKET_CHECK_DECODE_ASSERT_SVH

`ifndef SYNTHESIS
`define HBPCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");
`define HBPCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons next cycle");
`else
`define HBPCD_ASSERT_NOW(lbl, ante, cons)
`define HBPCD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/hbpcd_pkg.sv
package hbpcd_pkg;

  localparam int HEADER_BYTES = 5;

  localparam logic [1:0] SRC_INVALID = 2'd0;
  localparam logic [1:0] SRC_HEATER  = 2'd1;
  localparam logic [1:0] SRC_CONTROL = 2'd2;
  localparam logic [1:0] SRC_UNKNOWN = 2'd3;

  localparam logic [3:0] HEATER_SENDER = 4'h7;
  localparam logic [7:0] HEATER_TAG    = 8'h20;
  localparam logic [7:0] CONTROL_TAG   = 8'hbf;
  localparam logic [3:0] TEMP_CODE_MAX = 4'he;
  localparam logic [6:0] STARTUP_MASK  = 7'h7f;

  typedef logic [HEADER_BYTES-1:0][7:0] header_t;

  typedef struct packed {
    logic    length_ok;
    logic    parity_good;
    logic    xor_zero;
    header_t header;
  } packet_state_t;

  typedef struct packed {
    logic [1:0] source;
    logic [2:0] active_id;
    logic       in_use;
    logic       heater_on;
    logic [6:0] startup_state;
    logic [5:0] temperature_c;
    logic       temp_code_valid;
    logic [3:0] controller_id;
    logic       on_off_pressed;
    logic       priority_pressed;
    logic       temp_up_pressed;
    logic       temp_down_pressed;
  } result_t;

  function automatic logic [5:0] temp_lookup(input logic [3:0] code);
    logic [5:0] t;
    case (code)
      4'd0:    t = 6'd37;
      4'd1:    t = 6'd38;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd40;
      4'd4:    t = 6'd41;
      4'd5:    t = 6'd42;
      4'd6:    t = 6'd43;
      4'd7:    t = 6'd44;
      4'd8:    t = 6'd45;
      4'd9:    t = 6'd46;
      4'd10:   t = 6'd47;
      4'd11:   t = 6'd48;
      4'd12:   t = 6'd50;
      4'd13:   t = 6'd55;
      4'd14:   t = 6'd60;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

### rtl/core/heater_bus_packet_check_decode.sv
// Packet checker and decoder for a water-heater serial bus. Bytes come in one
// transaction each, end_of_packet marks the last byte, and that byte yields one
// result: the sender class (invalid, heater, control panel, unknown) with the
// heater or control fields decoded and the other set zero. A packet is invalid
// unless it has exactly PACKET_BYTES bytes, every byte has odd parity and the
// XOR of all bytes is zero. One byte is taken every cycle; a byte passes an
// input register, then the checksum/parity/header update and the decode feed
// the result register, which loads a result as its last byte leaves the input
// register. The input stalls only while a final byte sits in the input
// register and the previous result is still held at the output.
module heater_bus_packet_check_decode #(
  parameter int PACKET_BYTES = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       end_of_packet,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] source,
  output logic [2:0] active_id,
  output logic       in_use,
  output logic       heater_on,
  output logic [6:0] startup_state,
  output logic [5:0] temperature_c,
  output logic       temp_code_valid,
  output logic [3:0] controller_id,
  output logic       on_off_pressed,
  output logic       priority_pressed,
  output logic       temp_up_pressed,
  output logic       temp_down_pressed
);
  import hbpcd_pkg::*;

  `include "heater_bus_packet_check_decode_assert.svh"

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_eop;
  logic          s1_move;
  logic          out_free;
  packet_state_t pkt;
  result_t       res_next;
  result_t       res;
  logic          heater_zero;
  logic          control_zero;

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && (!s1_eop || out_free);
  assign in_stall = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
      s1_eop  <= end_of_packet;
    end
  end

  hbpcd_accum #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_move),
    .rx_byte      (s1_byte),
    .end_of_packet(s1_eop),
    .pkt          (pkt)
  );

  hbpcd_decode u_decode (
    .pkt(pkt),
    .res(res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_eop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_eop) begin
      res <= res_next;
    end
  end

  assign source            = res.source;
  assign active_id         = res.active_id;
  assign in_use            = res.in_use;
  assign heater_on         = res.heater_on;
  assign startup_state     = res.startup_state;
  assign temperature_c     = res.temperature_c;
  assign temp_code_valid   = res.temp_code_valid;
  assign controller_id     = res.controller_id;
  assign on_off_pressed    = res.on_off_pressed;
  assign priority_pressed  = res.priority_pressed;
  assign temp_up_pressed   = res.temp_up_pressed;
  assign temp_down_pressed = res.temp_down_pressed;

  assign heater_zero  = active_id == 3'd0 && in_use == 1'b0 && heater_on == 1'b0 &&
                        startup_state == 7'd0 && temperature_c == 6'd0 &&
                        temp_code_valid == 1'b0;
  assign control_zero = controller_id == 4'd0 && on_off_pressed == 1'b0 &&
                        priority_pressed == 1'b0 && temp_up_pressed == 1'b0 &&
                        temp_down_pressed == 1'b0;

  `HBPCD_ASSERT_NOW(a_heater_zero, out_valid && source != SRC_HEATER, heater_zero)
  `HBPCD_ASSERT_NOW(a_control_zero, out_valid && source != SRC_CONTROL, control_zero)
  `HBPCD_ASSERT_NOW(a_temp_range, out_valid && temp_code_valid, temperature_c >= 6'd37 && temperature_c <= 6'd60)
  `HBPCD_ASSERT_NOW(a_stall_cause, in_stall, s1_valid && s1_eop && out_valid && out_stall)
  `HBPCD_ASSERT_NEXT(a_result_load, s1_move && s1_eop, out_valid)

endmodule

### rtl/core/hbpcd_accum.sv
module hbpcd_accum #(
  parameter int PACKET_BYTES = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               rx_byte,
  input  logic                     end_of_packet,
  output hbpcd_pkg::packet_state_t pkt
);
  import hbpcd_pkg::*;

  localparam int CW = $clog2(PACKET_BYTES + 2);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [7:0]    xor_sum;
  logic [7:0]    xor_sum_next;
  logic          parity_good;
  logic          parity_good_next;
  header_t       header;
  header_t       header_next;

  always_comb begin
    count_next = (count < CW'(PACKET_BYTES + 1)) ? count + CW'(1) : count;
    xor_sum_next = xor_sum ^ rx_byte;
    parity_good_next = parity_good & (^rx_byte);
    header_next = header;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (count == CW'(i)) begin
        header_next[i] = rx_byte;
      end
    end
  end

  // view of the packet with the current byte included
  assign pkt.length_ok   = (count_next == CW'(PACKET_BYTES));
  assign pkt.parity_good = parity_good_next;
  assign pkt.xor_zero    = (xor_sum_next == 8'h00);
  assign pkt.header      = header_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      xor_sum     <= '0;
      parity_good <= 1'b1;
      header      <= '0;
    end else if (step) begin
      if (end_of_packet) begin
        count       <= '0;
        xor_sum     <= '0;
        parity_good <= 1'b1;
        header      <= '0;
      end else begin
        count       <= count_next;
        xor_sum     <= xor_sum_next;
        parity_good <= parity_good_next;
        header      <= header_next;
      end
    end
  end

endmodule

### rtl/core/hbpcd_decode.sv
module hbpcd_decode (
  input  hbpcd_pkg::packet_state_t pkt,
  output hbpcd_pkg::result_t       res
);
  import hbpcd_pkg::*;

  logic       pkt_ok;
  logic [3:0] sender;
  logic [3:0] code;

  assign pkt_ok = pkt.length_ok && pkt.parity_good && pkt.xor_zero;
  assign sender = pkt.header[0][3:0];
  assign code   = pkt.header[2][3:0];

  always_comb begin
    res = '0;
    if (!pkt_ok) begin
      res.source = SRC_INVALID;
    end else if (sender == HEATER_SENDER && pkt.header[4] == HEATER_TAG) begin
      res.source        = SRC_HEATER;
      res.active_id     = pkt.header[0][6:4];
      res.in_use        = pkt.header[2][4];
      res.heater_on     = pkt.header[1][6];
      res.startup_state = pkt.header[3][6:0] & STARTUP_MASK;
      if (code <= TEMP_CODE_MAX) begin
        res.temperature_c   = temp_lookup(code);
        res.temp_code_valid = 1'b1;
      end
    end else if (sender < HEATER_SENDER && pkt.header[4] == CONTROL_TAG) begin
      res.source            = SRC_CONTROL;
      res.controller_id     = sender;
      res.on_off_pressed    = pkt.header[1][0];
      res.priority_pressed  = pkt.header[1][2];
      res.temp_up_pressed   = pkt.header[2][0];
      res.temp_down_pressed = pkt.header[2][1];
    end else begin
      res.source = SRC_UNKNOWN;
    end
  end

endmodule
